>>> hw/rtl/wfd_pkg.sv
// Shared types, constants and byte-wide update functions for the deframer.
// No dependencies; the deframer modules and the testbench import this package.
package wfd_pkg;

	localparam logic [8:0]  PN9_SEED  = 9'h1FF;
	localparam logic [8:0]  PAD_MASK  = 9'h1F8;
	localparam logic [8:0]  PAD_ROUND = 9'd7;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h8408;
	localparam logic [7:0]  MIN_LEN   = 8'd2;
	localparam logic [7:0]  CRC_BYTES = 8'd2;

	typedef enum logic [2:0] {
		KIND_LENGTH  = 3'd0,
		KIND_PAYLOAD = 3'd1,
		KIND_CRC     = 3'd2,
		KIND_PAD     = 3'd3,
		KIND_REJECT  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		kind_t      byte_kind;
		logic       frame_end;
		logic       crc_good;
	} res_t;

	// Advance the PN9 generator (x^9+x^5+1) by eight bits
	function automatic logic [8:0] pn9_advance8(input logic [8:0] r_in);
		logic [8:0] r;
		logic       fb;
		r = r_in;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ r[5];
			r  = {fb, r[8:1]};
		end
		return r;
	endfunction

	// Fold one byte into the reflected CRC-16-CCITT
	function automatic logic [15:0] crc_update8(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = {1'b0, c[15:1]} ^ CRC_POLY;
			end else begin
				c = {1'b0, c[15:1]};
			end
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/wfd_if.sv
// Valid/ready channel interfaces of the deframer: received bytes in, tagged bytes out.
// Depends on nothing; field widths follow the byte and tag formats.
interface wfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wfd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_byte;
	logic [2:0] byte_kind;
	logic       frame_end;
	logic       crc_good;

	modport source (output valid, output plain_byte, output byte_kind, output frame_end,
		output crc_good, input ready);
	modport sink   (input valid, input plain_byte, input byte_kind, input frame_end,
		input crc_good, output ready);
endinterface

>>> hw/rtl/whitened_frame_deframer.sv
// Top level of the whitened frame deframer: input register and frame logic, result register.
// Depends on wfd_pkg, wfd_if (channel interfaces), wfd_core and wfd_out_stage.
//
//   channel  dir  payload                                         beat
//   rx       in   rx_byte[7:0]                                    one received byte
//   res      out  plain_byte[7:0] byte_kind[2:0] frame_end crc_good  one tagged byte
//
// One byte per cycle while res does not stall; a beat passes through the input register
// and then the result register around the PN9/CRC byte logic before it leaves on res.
// arst_n clears both stages and returns the frame state to waiting for a length byte.
// A stall on res holds the result register; rx keeps accepting until the input
// register is also full, so at most two beats sit inside the block.
module whitened_frame_deframer import wfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	wfd_rx_if.sink    rx,
	wfd_res_if.source res
);

	logic core_valid;
	res_t core_data;
	logic core_ready;

	wfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.res_valid (core_valid),
		.res_data  (core_data),
		.res_ready (core_ready)
	);

	wfd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (core_valid),
		.up_data  (core_data),
		.up_ready (core_ready),
		.res      (res)
	);

endmodule

>>> hw/rtl/wfd_core.sv
// Input register plus frame state: dewhitening, length decode, CRC and byte tagging.
// Depends on wfd_pkg and the wfd_rx_if interface.
module wfd_core import wfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	wfd_rx_if.sink    rx,
	output logic      res_valid,
	output res_t      res_data,
	input  logic      res_ready
);

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic        in_frame_q;
	logic [8:0]  pn9_q;
	logic [8:0]  bytes_left_q;
	logic [7:0]  checked_left_q;
	logic [15:0] crc_q;

	logic        advance;
	logic [8:0]  pn_use;
	logic [7:0]  plain;
	logic [8:0]  pn_next;
	logic        in_frame_n;
	logic [8:0]  bytes_left_n;
	logic [7:0]  checked_left_n;
	logic [15:0] crc_n;
	kind_t       kind;
	logic        frame_end;
	logic        crc_good;

	// Move the held beat on when the result register can take it
	assign advance  = valid_s1 && res_ready;
	assign rx.ready = !valid_s1 || res_ready;

	// Capture the incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Dewhiten: a length byte always restarts the sequence from the seed
	assign pn_use  = in_frame_q ? pn9_q : PN9_SEED;
	assign plain   = byte_s1 ^ pn_use[7:0];
	assign pn_next = pn9_advance8(pn_use);

	// Decode the byte and work out the next frame state
	always_comb begin
		in_frame_n     = in_frame_q;
		bytes_left_n   = bytes_left_q;
		checked_left_n = checked_left_q;
		crc_n          = crc_q;
		kind           = KIND_PAD;
		frame_end      = 1'b0;
		crc_good       = 1'b0;
		if (!in_frame_q) begin
			if (plain < MIN_LEN) begin
				kind = KIND_REJECT;
			end else begin
				kind           = KIND_LENGTH;
				in_frame_n     = 1'b1;
				bytes_left_n   = ({1'b0, plain} + PAD_ROUND) & PAD_MASK;
				checked_left_n = plain;
				crc_n          = CRC_INIT;
			end
		end else begin
			if (checked_left_q != 8'd0) begin
				crc_n          = crc_update8(crc_q, plain);
				kind           = (checked_left_q > CRC_BYTES) ? KIND_PAYLOAD : KIND_CRC;
				checked_left_n = checked_left_q - 8'd1;
			end
			if (bytes_left_q != 9'd0) begin
				bytes_left_n = bytes_left_q - 9'd1;
			end
			if (bytes_left_n == 9'd0) begin
				frame_end  = 1'b1;
				crc_good   = (crc_n == 16'd0);
				in_frame_n = 1'b0;
			end
		end
	end

	assign res_valid           = valid_s1;
	assign res_data.plain_byte = plain;
	assign res_data.byte_kind  = kind;
	assign res_data.frame_end  = frame_end;
	assign res_data.crc_good   = crc_good;

	// Commit the frame state as the beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			pn9_q          <= PN9_SEED;
			bytes_left_q   <= 9'd0;
			checked_left_q <= 8'd0;
			crc_q          <= CRC_INIT;
		end else if (advance) begin
			in_frame_q     <= in_frame_n;
			pn9_q          <= pn_next;
			bytes_left_q   <= bytes_left_n;
			checked_left_q <= checked_left_n;
			crc_q          <= crc_n;
		end
	end

	// Inside a frame there is always at least one byte still to come
	a_frame_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> bytes_left_q != 9'd0)
		else $error("in frame with no bytes left");

	// CRC-covered bytes never outnumber the padded frame
	a_checked_within: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, checked_left_q} <= bytes_left_q)
		else $error("checked count exceeds frame count");

	// Idle between frames leaves no byte counts behind
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> bytes_left_q == 9'd0 && checked_left_q == 8'd0)
		else $error("counts left over outside a frame");

endmodule

>>> hw/rtl/wfd_out_stage.sv
// Result register that decouples the deframer from a stalling consumer.
// Depends on wfd_pkg and the wfd_res_if interface.
module wfd_out_stage import wfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	input  res_t      up_data,
	output logic      up_ready,
	wfd_res_if.source res
);

	logic valid_s2;
	res_t data_s2;

	// Take a new beat when empty or when the held one is leaving
	assign up_ready = !valid_s2 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= up_data;
		end
	end

	assign res.valid      = valid_s2;
	assign res.plain_byte = data_s2.plain_byte;
	assign res.byte_kind  = data_s2.byte_kind;
	assign res.frame_end  = data_s2.frame_end;
	assign res.crc_good   = data_s2.crc_good;

	// A frame closes on a CRC byte or on padding
	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && data_s2.frame_end |->
			data_s2.byte_kind == KIND_CRC || data_s2.byte_kind == KIND_PAD)
		else $error("frame end on wrong byte kind");

	// A good-CRC flag only comes with the frame end
	a_good_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && data_s2.crc_good |-> data_s2.frame_end)
		else $error("crc_good outside frame end");

endmodule

>>> test/whitened_frame_deframer_test.sv
`timescale 1ns / 1ps
// Testbench for whitened_frame_deframer: directed table then random frames, scored against a
// local PN9/CRC deframing model. Depends on wfd_pkg, wfd_if and the deframer RTL.
module whitened_frame_deframer_test;
	import wfd_pkg::*;

	localparam logic [8:0] PN9_START    = 9'h1FF;
	localparam int         ITEM_TARGET  = 650;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         DRAIN_CYCLES = 8;
	localparam res_t       NO_RES       = '0;

	typedef struct {
		logic       in_frame;
		logic [8:0] pn;
		logic [8:0] frame_left;
		logic [7:0] covered_left;
		logic [15:0] fcs;
	} deframe_state_t;

	// one directed row: value is either the raw byte or the dewhitened byte
	typedef struct {
		bit         is_plain;
		logic [7:0] value;
		bit         typed;
		res_t       want;
	} stim_row_t;

	typedef struct {
		logic [7:0] rx;
		bit         typed;
		res_t       want;
	} rx_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wfd_rx_if  rx();
	wfd_res_if res();

	whitened_frame_deframer dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx.sink),
		.res   (res.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	deframe_state_t gen_state;
	deframe_state_t score_state;
	rx_beat_t       rx_beat_q[$];
	res_t           tagged_byte_q[$];
	int             errors = 0;
	int             beat_no = 0;
	int             idle_cycles = 0;
	bit             beat_taken = 0;

	// Advance the x^9+x^5+1 whitening sequence by one byte
	function automatic logic [8:0] pn9_next_byte(input logic [8:0] seq);
		for (int i = 0; i < 8; i++) begin
			seq = {seq[5] ^ seq[0], seq[8:1]};
		end
		return seq;
	endfunction

	// Reflected CRC-16-CCITT, one byte
	function automatic logic [15:0] fcs_fold(input logic [15:0] acc, input logic [7:0] data);
		acc[7:0] = acc[7:0] ^ data;
		for (int i = 0; i < 8; i++) begin
			acc = acc[0] ? ((acc >> 1) ^ 16'h8408) : (acc >> 1);
		end
		return acc;
	endfunction

	// Dewhiten and tag one received byte, updating the frame state
	function automatic res_t deframe_byte(inout deframe_state_t st, input logic [7:0] rx_val);
		res_t r;
		r = NO_RES;
		if (!st.in_frame) begin
			r.plain_byte = rx_val ^ PN9_START[7:0];
			st.pn = pn9_next_byte(PN9_START);
			if (r.plain_byte < 8'd2) begin
				r.byte_kind = KIND_REJECT;
			end else begin
				r.byte_kind     = KIND_LENGTH;
				st.in_frame     = 1'b1;
				st.frame_left   = ({1'b0, r.plain_byte} + 9'd7) & 9'h1F8;
				st.covered_left = r.plain_byte;
				st.fcs          = 16'hFFFF;
			end
		end else begin
			r.plain_byte = rx_val ^ st.pn[7:0];
			st.pn = pn9_next_byte(st.pn);
			if (st.covered_left != 8'd0) begin
				st.fcs = fcs_fold(st.fcs, r.plain_byte);
				r.byte_kind = (st.covered_left > 8'd2) ? KIND_PAYLOAD : KIND_CRC;
				st.covered_left--;
			end else begin
				r.byte_kind = KIND_PAD;
			end
			if (st.frame_left != 9'd0) begin
				st.frame_left--;
			end
			if (st.frame_left == 9'd0) begin
				r.frame_end = 1'b1;
				r.crc_good  = (st.fcs == 16'd0);
				st.in_frame = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic void clear_state(output deframe_state_t st);
		st.in_frame     = 1'b0;
		st.pn           = PN9_START;
		st.frame_left   = 9'd0;
		st.covered_left = 8'd0;
		st.fcs          = 16'hFFFF;
	endfunction

	// Queue one beat; a plain value is whitened with the sequence the block will apply
	task automatic queue_byte(input bit is_plain, input logic [7:0] value, input bit typed,
		input res_t want);
		rx_beat_t b;
		b.rx = value;
		if (is_plain) begin
			b.rx = value ^ (gen_state.in_frame ? gen_state.pn[7:0] : PN9_START[7:0]);
		end
		b.typed = typed;
		b.want  = want;
		void'(deframe_byte(gen_state, b.rx));
		rx_beat_q.push_back(b);
	endtask

	task automatic report(input string field, input int got, input int want);
		$display("ERROR result %0d: %s = 0x%0h, expected 0x%0h", beat_no, field, got, want);
		errors++;
	endtask

	// Sender: bursts of random length with random gaps; hold a beat until taken
	int sender_burst = 0;
	int sender_gap = 0;

	initial begin
		rx.valid   = 1'b0;
		rx.rx_byte = 8'h00;
		res.ready  = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n && !(rx.valid && !beat_taken)) begin
			beat_taken = 0;
			if (sender_gap > 0) begin
				sender_gap--;
				rx.valid <= 1'b0;
			end else if (rx_beat_q.size() > 0) begin
				rx.valid   <= 1'b1;
				rx.rx_byte <= rx_beat_q[0].rx;
				if (sender_burst > 0) begin
					sender_burst--;
				end else begin
					sender_burst = ($urandom_range(7) == 0) ? $urandom_range(40, 120)
						: $urandom_range(0, 15);
					sender_gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// Receiver: rotating stall pattern, redrawn whenever stall_age wraps, sometimes no stalls at all
	logic [15:0] stall_pat = 16'hFFFF;
	int          stall_age = 0;

	always @(negedge clk) begin
		if (stall_age == 0) begin
			case ($urandom_range(2))
				0: begin
					stall_pat = 16'hFFFF;
				end
				1: begin
					stall_pat = 16'($urandom()) | 16'h0001;
				end
				default: begin
					stall_pat = 16'($urandom() | $urandom()) | 16'h0001;
				end
			endcase
		end
		stall_age = (stall_age + 1) % 128;
		res.ready <= arst_n && stall_pat[0];
		stall_pat = {stall_pat[0], stall_pat[15:1]};
	end

	// Score: predict on each taken input beat, compare each taken result beat
	always @(posedge clk) begin
		rx_beat_t b;
		res_t     predicted;
		res_t     want;
		if (arst_n) begin
			if (rx.valid && rx.ready) begin
				b = rx_beat_q.pop_front();
				predicted = deframe_byte(score_state, rx.rx_byte);
				tagged_byte_q.push_back(b.typed ? b.want : predicted);
				beat_taken = 1;
			end
			if (res.valid && res.ready) begin
				if (tagged_byte_q.size() == 0) begin
					report("unexpected result", res.plain_byte, 0);
				end else begin
					want = tagged_byte_q.pop_front();
					if (res.plain_byte !== want.plain_byte)
						report("plain_byte", res.plain_byte, want.plain_byte);
					if (res.byte_kind !== want.byte_kind)
						report("byte_kind", res.byte_kind, want.byte_kind);
					if (res.frame_end !== want.frame_end)
						report("frame_end", res.frame_end, want.frame_end);
					if (res.crc_good !== want.crc_good)
						report("crc_good", res.crc_good, want.crc_good);
				end
				beat_no++;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n && !(rx.valid && rx.ready) && !(res.valid && res.ready)) begin
			idle_cycles++;
		end else begin
			idle_cycles = 0;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		stim_row_t  directed[20];
		logic [7:0] body[$];
		logic [15:0] fcs;
		int         pick;
		int         frame_len;
		int         padded;
		int         frame_cnt;
		int         idx;

		clear_state(gen_state);
		clear_state(score_state);

		// Two rejected lengths, a minimum frame with a good check, then a short bad frame
		directed = '{
			'{0, 8'hFF, 1, '{8'h00, KIND_REJECT, 1'b0, 1'b0}},
			'{0, 8'hFE, 1, '{8'h01, KIND_REJECT, 1'b0, 1'b0}},
			'{1, 8'h02, 1, '{8'h02, KIND_LENGTH, 1'b0, 1'b0}},
			'{1, 8'hFF, 1, '{8'hFF, KIND_CRC, 1'b0, 1'b0}},
			'{1, 8'hFF, 1, '{8'hFF, KIND_CRC, 1'b0, 1'b0}},
			'{0, 8'h00, 0, NO_RES},
			'{0, 8'hFF, 0, NO_RES},
			'{1, 8'h00, 1, '{8'h00, KIND_PAD, 1'b0, 1'b0}},
			'{1, 8'hFF, 1, '{8'hFF, KIND_PAD, 1'b0, 1'b0}},
			'{0, 8'hA5, 0, NO_RES},
			'{1, 8'h00, 1, '{8'h00, KIND_PAD, 1'b1, 1'b1}},
			'{1, 8'h03, 1, '{8'h03, KIND_LENGTH, 1'b0, 1'b0}},
			'{0, 8'h00, 0, NO_RES},
			'{0, 8'hFF, 0, NO_RES},
			'{0, 8'h80, 0, NO_RES},
			'{0, 8'h7F, 0, NO_RES},
			'{0, 8'h01, 0, NO_RES},
			'{0, 8'hFF, 0, NO_RES},
			'{0, 8'h00, 0, NO_RES},
			'{0, 8'h5A, 0, NO_RES}
		};
		foreach (directed[i]) begin
			queue_byte(directed[i].is_plain, directed[i].value, directed[i].typed,
				directed[i].want);
		end

		// Random part: mostly well-formed frames, some rejects and raw noise
		frame_cnt = 0;
		while (rx_beat_q.size() < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 78 || frame_cnt == 5) begin
				if (frame_cnt == 5) begin
					frame_len = $urandom_range(249, 255);
				end else if (pick < 70) begin
					frame_len = $urandom_range(2, 24);
				end else begin
					frame_len = $urandom_range(25, 60);
				end
				body.delete();
				fcs = 16'hFFFF;
				for (int i = 0; i < frame_len - 2; i++) begin
					body.push_back(8'($urandom_range(255)));
					fcs = fcs_fold(fcs, body[i]);
				end
				body.push_back(fcs[7:0]);
				body.push_back(fcs[15:8]);
				if ($urandom_range(4) == 0) begin
					idx = $urandom_range(body.size() - 1);
					body[idx] = body[idx] ^ (8'h01 << $urandom_range(7));
				end
				padded = ((frame_len + 7) / 8) * 8;
				for (int i = 0; i < padded - frame_len; i++) begin
					body.push_back(8'($urandom_range(255)));
				end
				queue_byte(1, frame_len[7:0], 0, NO_RES);
				foreach (body[i]) begin
					queue_byte(1, body[i], 0, NO_RES);
				end
				frame_cnt++;
			end else if (pick < 88) begin
				queue_byte(1, 8'($urandom_range(1)), 0, NO_RES);
			end else begin
				// raw noise, then flush whatever frame it opened
				repeat ($urandom_range(1, 4)) begin
					queue_byte(0, 8'($urandom_range(255)), 0, NO_RES);
				end
				while (gen_state.in_frame) begin
					queue_byte(0, 8'($urandom_range(255)), 0, NO_RES);
				end
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: all beats sent, all results back, then a quiet spell of DRAIN_CYCLES
		while (rx_beat_q.size() > 0 || tagged_byte_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> whitened_frame_deframer.f
hw/rtl/wfd_pkg.sv
hw/rtl/wfd_if.sv
hw/rtl/wfd_core.sv
hw/rtl/wfd_out_stage.sv
hw/rtl/whitened_frame_deframer.sv
test/whitened_frame_deframer_test.sv
